// File: sv/tcg_pkg.sv
package tcg_pkg;

	// Field widths fixed by the item formats
	localparam int FIELD_W = 24;
	localparam int MAG_W   = 18;
	localparam int FADE_W  = 25;
	localparam int CFG_W   = 16;
	localparam int CFG_IW  = 2;

	localparam logic [FADE_W-1:0] FADE_ONE = FADE_W'(1) << 24;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_OFF   = 2'd2
	} op_t;

	typedef enum logic [CFG_IW-1:0] {
		CFG_WAVEFORM  = 2'd0,
		CFG_GAIN      = 2'd1,
		CFG_INTENSITY = 2'd2,
		CFG_ENABLE    = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		WAVE_SINE     = 3'd0,
		WAVE_SQUARE   = 3'd1,
		WAVE_SAW      = 3'd2,
		WAVE_RAMPDOWN = 3'd3,
		WAVE_TRIANGLE = 3'd4
	} wave_t;

	typedef struct packed {
		logic [1:0]         op;
		logic [FIELD_W-1:0] phase_step;
		logic [FIELD_W-1:0] note_ticks;
		logic [FIELD_W-1:0] rest_len;
		logic [FIELD_W-1:0] dropoff_point;
		logic [FIELD_W-1:0] cutoff_point;
		logic [FIELD_W-1:0] fade_step;
		logic               reset_phase;
	} item_t;

	typedef struct packed {
		logic signed [15:0] sample_out;
		logic               note_active;
	} result_t;

	// Controller to datapath: at most one step per cycle, none while waiting for an item or a free output
	typedef struct packed {
		logic accept;
		logic dec;
		logic wave;
		logic gain;
		logic fade;
		logic drop;
		logic div_step;
		logic div_last;
		logic intens;
		logic finish;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic tick_in;
		logic run;
		logic drop_need;
		logic out_free;
	} sts_t;

endpackage

// File: sv/tone_channel_generator.sv
// Note start and note off are taken in ST_IDLE and give no result.
// A tick passes ST_DEC then ST_DONE when silent; when sounding, ST_WAVE, ST_GAIN, ST_FADE
// and ST_INTENS lie between, and ST_DROP and the restoring divider (ST_DIV) follow ST_FADE
// when the linear dropoff applies. No new item is taken until the result is registered.
// ST_DONE waits on result_ready while the output is full. The steps share one multiplier.
// Reset (arst_n low) clears the channel state but t_q and den_q, and loads the register defaults.
module tone_channel_generator #(
	parameter int PHASE_BITS       = 24,
	parameter int SINE_TABLE_DEPTH = 256,
	parameter int TICK_BITS        = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  tcg_pkg::item_t              item,
	output logic                        result_valid,
	input  logic                        result_ready,
	output tcg_pkg::result_t            result,
	input  logic                        cfg_we,
	input  logic [tcg_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [tcg_pkg::CFG_W-1:0]   cfg_data
);
	import tcg_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tcg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	tcg_dpath #(
		.PHASE_BITS       (PHASE_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.TICK_BITS        (TICK_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// At most one datapath step per cycle
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.dec, cmd.wave, cmd.gain, cmd.fade, cmd.drop,
			cmd.div_step, cmd.intens, cmd.finish}))
		else $error("more than one step command");

	// Never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!result_valid || result_ready))
		else $error("result overwritten");

	// Input stays closed while the divider runs
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |=> !item_ready)
		else $error("input opened during division");

endmodule

// File: sv/tcg_ctrl.sv
module tcg_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	input  tcg_pkg::sts_t sts,
	output tcg_pkg::cmd_t cmd
);
	import tcg_pkg::*;

	localparam int CNT_W = $clog2(MAG_W);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_DEC    = 9'b000000010,
		ST_WAVE   = 9'b000000100,
		ST_GAIN   = 9'b000001000,
		ST_FADE   = 9'b000010000,
		ST_DROP   = 9'b000100000,
		ST_DIV    = 9'b001000000,
		ST_INTENS = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

	state_t            state_q, state_nx;
	logic [CNT_W-1:0]  cnt_q;

	assign item_ready = (state_q == ST_IDLE);

	// Next state and step commands
	always_comb begin
		state_nx = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.accept = 1'b1;
					if (sts.tick_in) state_nx = ST_DEC;
				end
			end
			ST_DEC: begin
				cmd.dec = 1'b1;
				state_nx = sts.run ? ST_WAVE : ST_DONE;
			end
			ST_WAVE: begin
				cmd.wave = 1'b1;
				state_nx = ST_GAIN;
			end
			ST_GAIN: begin
				cmd.gain = 1'b1;
				state_nx = ST_FADE;
			end
			ST_FADE: begin
				cmd.fade = 1'b1;
				state_nx = sts.drop_need ? ST_DROP : ST_INTENS;
			end
			ST_DROP: begin
				cmd.drop = 1'b1;
				state_nx = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					cmd.div_last = 1'b1;
					state_nx = ST_INTENS;
				end
			end
			ST_INTENS: begin
				cmd.intens = 1'b1;
				state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			// Count quotient bits of the dropoff division
			if (cmd.drop) cnt_q <= CNT_W'(MAG_W - 1);
			else if (cmd.div_step) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: sv/tcg_dpath.sv
module tcg_dpath #(
	parameter int PHASE_BITS       = 24,
	parameter int SINE_TABLE_DEPTH = 256,
	parameter int TICK_BITS        = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tcg_pkg::item_t                      item,
	input  logic                                cfg_we,
	input  logic [tcg_pkg::CFG_IW-1:0]          cfg_index,
	input  logic [tcg_pkg::CFG_W-1:0]           cfg_data,
	input  tcg_pkg::cmd_t                       cmd,
	output tcg_pkg::sts_t                       sts,
	output logic                                result_valid,
	input  logic                                result_ready,
	output tcg_pkg::result_t                    result
);
	import tcg_pkg::*;

	localparam int PB     = PHASE_BITS;
	localparam int TB     = TICK_BITS;
	localparam int SIN_AW = $clog2(SINE_TABLE_DEPTH);
	localparam int MB_W   = (FADE_W > TB) ? FADE_W : TB;
	localparam int PR_W   = MAG_W + MB_W;
	localparam int UP     = (PB >= FIELD_W) ? PB - FIELD_W : 0;
	localparam int DN     = (PB < FIELD_W) ? FIELD_W - PB : 0;
	localparam logic [63:0] FULL    = 64'd1 << PB;
	localparam logic [63:0] HALF    = FULL >> 1;
	localparam logic [63:0] QUART   = FULL >> 2;
	localparam logic [63:0] HALF_PI = 64'd1686629713;
	localparam logic [63:0] DEPTH   = 64'(SINE_TABLE_DEPTH);

	// Sine table: magnitude and sign per entry, built at elaboration
	logic [MAG_W-1:0] sine_mag [SINE_TABLE_DEPTH];
	logic             sine_neg [SINE_TABLE_DEPTH];

	for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_sine
		localparam logic [63:0] QD = (64'(i) * 64'd4) / SINE_TABLE_DEPTH;
		localparam logic [63:0] RD = (64'(i) * 64'd4) % SINE_TABLE_DEPTH;
		localparam logic [63:0] U  = (QD % 64'd2 == 64'd1) ? DEPTH - RD : RD;
		localparam logic [63:0] A  = (HALF_PI * U) / SINE_TABLE_DEPTH;
		localparam logic [63:0] A2 = (A * A) >> 30;
		localparam logic [63:0] K1 = ((A * A2) >> 30) / 6;
		localparam logic [63:0] K2 = ((K1 * A2) >> 30) / 20;
		localparam logic [63:0] K3 = ((K2 * A2) >> 30) / 42;
		localparam logic [63:0] K4 = ((K3 * A2) >> 30) / 72;
		localparam logic [63:0] K5 = ((K4 * A2) >> 30) / 110;
		localparam logic [63:0] K6 = ((K5 * A2) >> 30) / 156;
		localparam logic [63:0] S  = A - K1 + K2 - K3 + K4 - K5 + K6;
		localparam logic [63:0] E  = (S * 64'd32768 + (64'd1 << 29)) >> 30;
		assign sine_mag[i] = MAG_W'(E);
		assign sine_neg[i] = (QD >= 64'd2);
	end

	// Configuration
	logic [2:0]       waveform_q;
	logic [CFG_W-1:0] gain_q, intens_q;
	logic             enable_q;

	// Channel state
	logic [PB-1:0]     phase_q, step_q;
	logic [TB-1:0]     tr_q, rest_q, drop_q, cut_q, t_q, den_q;
	logic [FADE_W-1:0] fade_q;
	logic [FIELD_W-1:0] fdec_q;
	logic              fading_q;

	// Working registers
	logic [MAG_W-1:0] mag_q, lo_q, sin_mag_s1;
	logic             neg_q, sin_neg_s1;
	logic [TB-1:0]    rem_q;
	result_t          out_q;
	logic             out_valid_q;

	logic [TB-1:0]    tr_m1;
	logic [63:0]      sin_prod, pe;
	logic [SIN_AW-1:0] sin_idx;
	logic [MAG_W-1:0] wave_mag;
	logic             wave_neg;
	logic [MB_W-1:0]  mul_b;
	logic [PR_W-1:0]  prod;
	logic [TB:0]      rem2;
	logic             qbit;
	logic [15:0]      sat;

	assign tr_m1 = tr_q - 1'b1;

	// Status to the controller
	assign sts.tick_in   = (item.op == OP_TICK);
	assign sts.run       = (tr_q != '0) && (tr_m1 >= rest_q) && enable_q;
	assign sts.drop_need = (t_q < drop_q);
	assign sts.out_free  = !out_valid_q || result_ready;

	// Table address from the phase
	assign sin_prod = 64'(phase_q) * DEPTH;
	assign sin_idx  = sin_prod[PB +: SIN_AW];

	// Waveform magnitude and sign
	assign pe = 64'(phase_q);
	always_comb begin
		wave_mag = '0;
		wave_neg = 1'b0;
		case (waveform_q)
			WAVE_SINE: begin
				wave_mag = sin_mag_s1;
				wave_neg = sin_neg_s1 && (sin_mag_s1 != '0);
			end
			WAVE_SQUARE: begin
				wave_mag = MAG_W'(32768);
				wave_neg = !(pe > HALF);
			end
			WAVE_SAW: begin
				if (pe < HALF) wave_mag = MAG_W'((pe << 16) >> PB);
				else begin
					wave_neg = 1'b1;
					wave_mag = MAG_W'(((FULL - pe) << 16) >> PB);
				end
			end
			WAVE_RAMPDOWN: begin
				if (pe < HALF) begin
					wave_neg = 1'b1;
					wave_mag = MAG_W'((pe << 16) >> PB);
				end else wave_mag = MAG_W'(((FULL - pe) << 16) >> PB);
			end
			WAVE_TRIANGLE: begin
				if (pe < QUART) wave_mag = MAG_W'((pe << 17) >> PB);
				else if (pe < HALF + QUART) begin
					if (pe <= HALF) wave_mag = MAG_W'(((HALF - pe) << 17) >> PB);
					else begin
						wave_neg = 1'b1;
						wave_mag = MAG_W'(((pe - HALF) << 17) >> PB);
					end
				end else begin
					wave_neg = 1'b1;
					wave_mag = MAG_W'(((FULL - pe) << 17) >> PB);
				end
			end
			default: wave_mag = '0;
		endcase
	end

	// Shared multiplier, operand chosen by step
	always_comb begin
		mul_b = '0;
		if (cmd.gain) mul_b = MB_W'(gain_q);
		else if (cmd.fade) mul_b = MB_W'(fade_q);
		else if (cmd.drop) mul_b = MB_W'(t_q - rest_q);
		else if (cmd.intens) mul_b = MB_W'(intens_q);
	end
	assign prod = PR_W'(mag_q) * PR_W'(mul_b);

	// Restoring divide step, one quotient bit
	assign rem2 = {rem_q, lo_q[MAG_W-1]};
	assign qbit = (rem2 >= {1'b0, den_q});

	// Saturate to Q1.15
	always_comb begin
		if (neg_q) sat = (mag_q > MAG_W'(32768)) ? 16'h8000 : 16'(~mag_q + 1'b1);
		else sat = (mag_q > MAG_W'(32767)) ? 16'h7fff : mag_q[15:0];
	end

	// Configuration and channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waveform_q <= WAVE_TRIANGLE;
			gain_q     <= CFG_W'(32768);
			intens_q   <= CFG_W'(5000);
			enable_q   <= 1'b1;
			phase_q    <= '0;
			step_q     <= '0;
			tr_q       <= '0;
			rest_q     <= '0;
			drop_q     <= '0;
			cut_q      <= '0;
			fade_q     <= '0;
			fdec_q     <= '0;
			fading_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_WAVEFORM:  waveform_q <= cfg_data[2:0];
					CFG_GAIN:      gain_q     <= cfg_data;
					CFG_INTENSITY: intens_q   <= cfg_data;
					CFG_ENABLE:    enable_q   <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.accept) begin
				case (item.op)
					OP_START: begin
						step_q <= PB'((64'(item.phase_step) << UP) >> DN);
						tr_q   <= TB'(item.note_ticks);
						rest_q <= TB'(item.rest_len);
						drop_q <= TB'(item.dropoff_point);
						cut_q  <= TB'(item.cutoff_point);
						if (item.reset_phase) phase_q <= '0;
					end
					OP_OFF: begin
						if (!fading_q) begin
							fading_q <= 1'b1;
							fade_q   <= FADE_ONE;
						end
						fdec_q <= item.fade_step;
					end
					default: ;
				endcase
			end
			// Count the note down
			if (cmd.dec && tr_q != '0) tr_q <= tr_m1;
			// Advance phase and fade; end the note when the fade is spent
			if (cmd.fade) begin
				phase_q <= phase_q + step_q;
				if (fading_q) begin
					if (fade_q == '0) begin
						fading_q <= 1'b0;
						tr_q     <= '0;
					end
					fade_q <= (fade_q > FADE_W'(fdec_q)) ? fade_q - FADE_W'(fdec_q) : '0;
				end
			end
			if (cmd.intens && tr_q == cut_q) tr_q <= '0;
		end
	end

	// Sample arithmetic
	always_ff @(posedge clk) begin
		if (cmd.dec) begin
			t_q        <= tr_m1;
			mag_q      <= '0;
			neg_q      <= 1'b0;
			sin_mag_s1 <= sine_mag[sin_idx];
			sin_neg_s1 <= sine_neg[sin_idx];
		end
		if (cmd.wave) begin
			mag_q <= wave_mag;
			neg_q <= wave_neg;
		end
		if (cmd.gain) mag_q <= MAG_W'(prod >> 15);
		if (cmd.fade && fading_q) mag_q <= MAG_W'(prod >> 24);
		if (cmd.drop) begin
			lo_q  <= prod[MAG_W-1:0];
			rem_q <= prod[MAG_W +: TB];
			den_q <= drop_q - rest_q;
		end
		if (cmd.div_step) begin
			rem_q <= qbit ? TB'(rem2 - {1'b0, den_q}) : rem2[TB-1:0];
			lo_q  <= {lo_q[MAG_W-2:0], qbit};
			if (cmd.div_last) mag_q <= {lo_q[MAG_W-2:0], qbit};
		end
		if (cmd.intens) mag_q <= MAG_W'(prod >> 15);
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (result_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.sample_out  <= sat;
			out_q.note_active <= (tr_q != '0);
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
